[design/pcs1d_pkg.sv]
package pcs1d_pkg;

    localparam int MAX_BINS = 1024;
    localparam int BIN_W    = $clog2(MAX_BINS);      // bin index
    localparam int CNT_W    = $clog2(MAX_BINS + 1);  // bin count, prefix address
    localparam int WGT_W    = 16;
    localparam int SUM_W    = 26;
    localparam int U_W      = 16;
    localparam int FRAC_W   = 16;
    localparam int PROD_W   = U_W + SUM_W;           // u * total
    localparam int KD_W     = 2 * SUM_W;             // (k << 16) * step
    localparam int NUM_W    = KD_W + 2;              // divider numerator
    localparam int DEN_W    = CNT_W + SUM_W;         // n * step
    localparam int QUO_W    = 26;                    // widest quotient (density)
    localparam int QSEL_W   = $clog2(QUO_W + 1);
    localparam int WN_W     = WGT_W + CNT_W;
    localparam int PROB_W   = 17;

    localparam logic [1:0] ACT_LOAD   = 2'd0;
    localparam logic [1:0] ACT_BUILD  = 2'd1;
    localparam logic [1:0] ACT_SAMPLE = 2'd2;
    localparam logic [1:0] ACT_PDF    = 2'd3;

    localparam logic [QSEL_W-1:0] QBITS_POS  = QSEL_W'(16);
    localparam logic [QSEL_W-1:0] QBITS_DEN  = QSEL_W'(26);
    localparam logic [QSEL_W-1:0] QBITS_PROB = QSEL_W'(17);

    typedef struct packed {
        logic              start;
        logic [QSEL_W-1:0] qbits;   // quotient bits; result saturates at 2^qbits-1
    } div_req_t;

endpackage

[design/pcs1d_div.sv]
module pcs1d_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  pcs1d_pkg::div_req_t       req,
    input  logic [pcs1d_pkg::NUM_W-1:0] numer,
    input  logic [pcs1d_pkg::DEN_W-1:0] denom,
    output logic                      done,
    output logic [pcs1d_pkg::QUO_W-1:0] quot
);
    import pcs1d_pkg::*;

    localparam int WIDE_W = DEN_W + QUO_W + 1;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [WIDE_W-1:0] rem_reg, rem_next;
    logic [WIDE_W-1:0] dsh_reg, dsh_next;
    logic [QSEL_W-1:0] cnt_reg, cnt_next;
    logic [QUO_W-1:0]  quot_reg, quot_next;

    logic [WIDE_W-1:0] den_wide;
    logic [WIDE_W-1:0] num_wide;
    logic [WIDE_W-1:0] limit;
    logic              ge;

    assign den_wide = WIDE_W'(denom);
    assign num_wide = WIDE_W'(numer);
    assign limit    = den_wide << req.qbits;
    assign ge       = rem_reg >= dsh_reg;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        cnt_next  = cnt_reg;
        quot_next = quot_reg;
        if (busy_reg)
        begin
            rem_next  = ge ? rem_reg - dsh_reg : rem_reg;
            quot_next = {quot_reg[QUO_W-2:0], ge};
            dsh_next  = dsh_reg >> 1;
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == QSEL_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (req.start)
        begin
            if (num_wide >= limit)
            begin
                // quotient too big: saturate
                quot_next = ~({QUO_W{1'b1}} << req.qbits);
                done_next = 1'b1;
            end
            else
            begin
                rem_next  = num_wide;
                dsh_next  = den_wide << (req.qbits - 1'b1);
                cnt_next  = req.qbits;
                quot_next = '0;
                busy_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            rem_reg  <= '0;
            dsh_reg  <= '0;
            cnt_reg  <= '0;
            quot_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            rem_reg  <= rem_next;
            dsh_reg  <= dsh_next;
            cnt_reg  <= cnt_next;
            quot_reg <= quot_next;
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

[design/piecewise_constant_sampler_1d.sv]
// A load writes the weight at accept and returns no result. A build, a pdf query or a sample
// each return one result; a sample runs a binary search, a fetch and two divisions (one if the total is zero).
// Throughput: one item at a time; the item rate is set by the memory
// search loop and the bit-serial divider (one quotient bit per cycle).
// Reset: asynchronous, active low; bin_count returns to 1024 and the total to zero.
// Memory contents are not cleared: entries are undefined until loaded or built.
module piecewise_constant_sampler_1d (
    input  logic                               clk,
    input  logic                               rst_n,
    // configuration
    input  logic                               cfg_write_en,
    input  logic [pcs1d_pkg::CNT_W-1:0]        cfg_write_data,
    // input channel
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [1:0]                         action,
    input  logic [pcs1d_pkg::BIN_W-1:0]        bin_index,
    input  logic [pcs1d_pkg::WGT_W-1:0]        weight,
    input  logic [pcs1d_pkg::U_W-1:0]          uniform_draw,
    // output channel
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [1:0]                         kind,
    output logic [pcs1d_pkg::BIN_W-1:0]        chosen_bin,
    output logic [pcs1d_pkg::FRAC_W-1:0]       position,
    output logic [pcs1d_pkg::SUM_W-1:0]        density,
    output logic [pcs1d_pkg::PROB_W-1:0]       probability,
    output logic [pcs1d_pkg::SUM_W-1:0]        weight_total
);
    import pcs1d_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_BUILD_INIT,
        ST_BUILD,
        ST_SRCH_INIT,
        ST_SRCH,
        ST_SRCH_WAIT,
        ST_FETCH0,
        ST_FETCH1,
        ST_FETCH2,
        ST_MUL,
        ST_NUM,
        ST_DIV_POS,
        ST_DIV_DEN,
        ST_PDF_RD,
        ST_PDF_WAIT,
        ST_DIV_PDF,
        ST_DONE
    } state_t;

    // ---------------------------------------------------------------
    // Memories: bin weights and prefix sums (prefix has n+1 entries)
    // ---------------------------------------------------------------
    logic [WGT_W-1:0] weight_mem [MAX_BINS];
    logic [SUM_W-1:0] prefix_mem [MAX_BINS + 1];

    logic             wm_we;
    logic [BIN_W-1:0] wm_waddr;
    logic [BIN_W-1:0] wm_raddr;
    logic [WGT_W-1:0] wm_rdata_reg;

    logic             pm_we;
    logic [CNT_W-1:0] pm_waddr;
    logic [SUM_W-1:0] pm_wdata;
    logic [CNT_W-1:0] pm_raddr;
    logic [SUM_W-1:0] pm_rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wm_we)
        begin
            weight_mem[wm_waddr] <= weight;
        end
        wm_rdata_reg <= weight_mem[wm_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (pm_we)
        begin
            prefix_mem[pm_waddr] <= pm_wdata;
        end
        pm_rdata_reg <= prefix_mem[pm_raddr];
    end

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  bin_count_reg, bin_count_next;
    logic [SUM_W-1:0]  total_reg, total_next;
    logic [1:0]        act_reg, act_next;
    logic [BIN_W-1:0]  idx_reg, idx_next;
    logic [U_W-1:0]    u_reg, u_next;
    // build
    logic [CNT_W-1:0]  rd_idx_reg, rd_idx_next;
    logic              pend_reg, pend_next;
    logic [CNT_W-1:0]  pend_addr_reg, pend_addr_next;
    logic [SUM_W-1:0]  acc_reg, acc_next;
    // search and sample arithmetic
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [CNT_W-1:0]  start_reg, start_next;
    logic [CNT_W-1:0]  len_reg, len_next;
    logic [BIN_W-1:0]  k_reg, k_next;
    logic [SUM_W-1:0]  pk_reg, pk_next;
    logic [WGT_W-1:0]  wk_reg, wk_next;
    logic [SUM_W-1:0]  d_reg, d_next;
    logic [KD_W-1:0]   kd_reg, kd_next;
    logic [DEN_W-1:0]  nd_reg, nd_next;
    logic [PROD_W-1:0] frac_reg, frac_next;
    logic [WN_W-1:0]   wn_reg, wn_next;
    // divider request
    div_req_t          div_req_reg, div_req_next;
    logic [NUM_W-1:0]  numer_reg, numer_next;
    logic [DEN_W-1:0]  denom_reg, denom_next;
    // finished result
    logic [BIN_W-1:0]  res_bin_reg, res_bin_next;
    logic [FRAC_W-1:0] res_pos_reg, res_pos_next;
    logic [SUM_W-1:0]  res_den_reg, res_den_next;
    logic [PROB_W-1:0] res_prob_reg, res_prob_next;
    logic [SUM_W-1:0]  res_total_reg, res_total_next;
    // output stage
    logic              out_valid_reg, out_valid_next;
    logic [1:0]        kind_reg, kind_next;
    logic [BIN_W-1:0]  bin_reg, bin_next;
    logic [FRAC_W-1:0] pos_reg, pos_next;
    logic [SUM_W-1:0]  den_reg, den_next;
    logic [PROB_W-1:0] prob_reg, prob_next;
    logic [SUM_W-1:0]  wtot_reg, wtot_next;

    // ---------------------------------------------------------------
    // Shared datapath terms
    // ---------------------------------------------------------------
    logic [CNT_W-1:0]  n;          // bin_count saturated to 1..MAX_BINS
    logic              in_accept;
    logic              total_zero;
    logic [CNT_W-1:0]  half;
    logic [CNT_W-1:0]  mid;
    logic              cmp_lin;    // uniform cdf test
    logic              cmp_mem;    // stored cdf test
    logic [SUM_W-1:0]  k_sh;       // k << 16
    logic [PROD_W-1:0] pk_sh;
    logic              div_done;
    logic [QUO_W-1:0]  div_quot;

    always_comb
    begin
        if (bin_count_reg == '0)
        begin
            n = CNT_W'(1);
        end
        else if (bin_count_reg > CNT_W'(MAX_BINS))
        begin
            n = CNT_W'(MAX_BINS);
        end
        else
        begin
            n = bin_count_reg;
        end
    end

    assign in_stall   = (state_reg != ST_IDLE);
    assign in_accept  = in_valid && !in_stall;
    assign total_zero = (total_reg == '0);
    assign half       = len_reg >> 1;
    assign mid        = start_reg + half;
    assign cmp_lin    = PROD_W'({mid, {FRAC_W{1'b0}}}) <= prod_reg;
    assign cmp_mem    = PROD_W'({pm_rdata_reg, {FRAC_W{1'b0}}}) <= prod_reg;
    assign k_sh       = SUM_W'({k_reg, {FRAC_W{1'b0}}});
    assign pk_sh      = PROD_W'({pk_reg, {FRAC_W{1'b0}}});

    pcs1d_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req_reg),
        .numer (numer_reg),
        .denom (denom_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    // Memory port control
    always_comb
    begin
        wm_we    = in_accept && (action == ACT_LOAD) && (CNT_W'(bin_index) < n);
        wm_waddr = bin_index;

        unique case (state_reg)
            ST_BUILD:  wm_raddr = rd_idx_reg[BIN_W-1:0];
            ST_FETCH0: wm_raddr = k_reg;
            default:   wm_raddr = idx_reg;
        endcase

        unique case (state_reg)
            ST_SRCH:   pm_raddr = mid;
            ST_FETCH0: pm_raddr = CNT_W'(k_reg);
            default:   pm_raddr = CNT_W'(k_reg) + CNT_W'(1);
        endcase

        pm_we    = 1'b0;
        pm_waddr = pend_addr_reg;
        pm_wdata = acc_reg + SUM_W'(wm_rdata_reg);
        if (state_reg == ST_BUILD_INIT)
        begin
            pm_we    = 1'b1;
            pm_waddr = '0;
            pm_wdata = '0;
        end
        else if (state_reg == ST_BUILD && pend_reg)
        begin
            pm_we = 1'b1;
        end
    end

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        bin_count_next = cfg_write_en ? cfg_write_data : bin_count_reg;
        total_next     = total_reg;
        act_next       = act_reg;
        idx_next       = idx_reg;
        u_next         = u_reg;
        rd_idx_next    = rd_idx_reg;
        pend_next      = pend_reg;
        pend_addr_next = pend_addr_reg;
        acc_next       = acc_reg;
        prod_next      = prod_reg;
        start_next     = start_reg;
        len_next       = len_reg;
        k_next         = k_reg;
        pk_next        = pk_reg;
        wk_next        = wk_reg;
        d_next         = d_reg;
        kd_next        = kd_reg;
        nd_next        = nd_reg;
        frac_next      = frac_reg;
        wn_next        = wn_reg;
        div_req_next   = div_req_reg;
        div_req_next.start = 1'b0;
        numer_next     = numer_reg;
        denom_next     = denom_reg;
        res_bin_next   = res_bin_reg;
        res_pos_next   = res_pos_reg;
        res_den_next   = res_den_reg;
        res_prob_next  = res_prob_reg;
        res_total_next = res_total_reg;
        out_valid_next = out_valid_reg && out_stall;
        kind_next      = kind_reg;
        bin_next       = bin_reg;
        pos_next       = pos_reg;
        den_next       = den_reg;
        prob_next      = prob_reg;
        wtot_next      = wtot_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    act_next       = action;
                    idx_next       = bin_index;
                    u_next         = uniform_draw;
                    res_bin_next   = '0;
                    res_pos_next   = '0;
                    res_den_next   = '0;
                    res_prob_next  = '0;
                    res_total_next = '0;
                    case (action)
                        ACT_BUILD:  state_next = ST_BUILD_INIT;
                        ACT_SAMPLE: state_next = ST_SRCH_INIT;
                        ACT_PDF:
                        begin
                            if (CNT_W'(bin_index) < n && !total_zero)
                            begin
                                state_next = ST_PDF_RD;
                            end
                            else
                            begin
                                state_next = ST_DONE;
                            end
                        end
                        default:    state_next = ST_IDLE;  // load: written at accept
                    endcase
                end
            end

            ST_BUILD_INIT:
            begin
                acc_next    = '0;
                rd_idx_next = '0;
                pend_next   = 1'b0;
                state_next  = ST_BUILD;
            end

            ST_BUILD:
            begin
                // read weight i, then add and write prefix i+1 in the next cycle
                if (pend_reg)
                begin
                    acc_next = pm_wdata;
                end
                if (rd_idx_reg < n)
                begin
                    rd_idx_next    = rd_idx_reg + CNT_W'(1);
                    pend_next      = 1'b1;
                    pend_addr_next = rd_idx_reg + CNT_W'(1);
                end
                else
                begin
                    pend_next = 1'b0;
                end
                if (rd_idx_reg == n && !pend_reg)
                begin
                    total_next     = acc_reg;
                    res_total_next = acc_reg;
                    state_next     = ST_DONE;
                end
            end

            ST_SRCH_INIT:
            begin
                if (total_zero)
                begin
                    prod_next = PROD_W'(u_reg) * PROD_W'(n);
                end
                else
                begin
                    prod_next = PROD_W'(u_reg) * PROD_W'(total_reg);
                end
                start_next = '0;
                len_next   = n + CNT_W'(1);
                state_next = ST_SRCH;
            end

            ST_SRCH:
            begin
                if (len_reg == '0)
                begin
                    if (start_reg == '0)
                    begin
                        k_next = '0;
                    end
                    else if (start_reg > n)
                    begin
                        k_next = BIN_W'(n - CNT_W'(1));
                    end
                    else
                    begin
                        k_next = BIN_W'(start_reg - CNT_W'(1));
                    end
                    state_next = total_zero ? ST_MUL : ST_FETCH0;
                end
                else if (total_zero)
                begin
                    if (cmp_lin)
                    begin
                        start_next = mid + CNT_W'(1);
                        len_next   = len_reg - half - CNT_W'(1);
                    end
                    else
                    begin
                        len_next = half;
                    end
                end
                else
                begin
                    state_next = ST_SRCH_WAIT;   // prefix[mid] read issued
                end
            end

            ST_SRCH_WAIT:
            begin
                if (cmp_mem)
                begin
                    start_next = mid + CNT_W'(1);
                    len_next   = len_reg - half - CNT_W'(1);
                end
                else
                begin
                    len_next = half;
                end
                state_next = ST_SRCH;
            end

            ST_FETCH0:
            begin
                state_next = ST_FETCH1;          // prefix[k], weight[k] read
            end

            ST_FETCH1:
            begin
                pk_next    = pm_rdata_reg;
                wk_next    = wm_rdata_reg;
                state_next = ST_FETCH2;          // prefix[k+1] read
            end

            ST_FETCH2:
            begin
                d_next     = pm_rdata_reg - pk_reg;
                state_next = ST_MUL;
            end

            ST_MUL:
            begin
                res_bin_next = k_reg;
                kd_next      = k_sh * d_reg;
                nd_next      = n * d_reg;
                wn_next      = wk_reg * n;
                frac_next    = (prod_reg > pk_sh) ? prod_reg - pk_sh : '0;
                if (total_zero)
                begin
                    // max(u*n, k<<16) / n
                    if (prod_reg > PROD_W'(k_sh))
                    begin
                        numer_next = NUM_W'(prod_reg);
                    end
                    else
                    begin
                        numer_next = NUM_W'(k_sh);
                    end
                    denom_next         = DEN_W'(n);
                    div_req_next.start = 1'b1;
                    div_req_next.qbits = QBITS_POS;
                    state_next         = ST_DIV_POS;
                end
                else if (d_reg == '0)
                begin
                    // empty bin: position is the bin start
                    numer_next         = NUM_W'(k_sh);
                    denom_next         = DEN_W'(n);
                    div_req_next.start = 1'b1;
                    div_req_next.qbits = QBITS_POS;
                    state_next         = ST_DIV_POS;
                end
                else
                begin
                    state_next = ST_NUM;
                end
            end

            ST_NUM:
            begin
                numer_next         = NUM_W'(kd_reg) + NUM_W'(frac_reg);
                denom_next         = nd_reg;
                div_req_next.start = 1'b1;
                div_req_next.qbits = QBITS_POS;
                state_next         = ST_DIV_POS;
            end

            ST_DIV_POS:
            begin
                if (div_done)
                begin
                    res_pos_next = div_quot[FRAC_W-1:0];
                    if (total_zero)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        numer_next         = NUM_W'({wn_reg, {FRAC_W{1'b0}}});
                        denom_next         = DEN_W'(total_reg);
                        div_req_next.start = 1'b1;
                        div_req_next.qbits = QBITS_DEN;
                        state_next         = ST_DIV_DEN;
                    end
                end
            end

            ST_DIV_DEN:
            begin
                if (div_done)
                begin
                    res_den_next = div_quot;
                    state_next   = ST_DONE;
                end
            end

            ST_PDF_RD:
            begin
                state_next = ST_PDF_WAIT;        // weight[idx] read
            end

            ST_PDF_WAIT:
            begin
                numer_next         = NUM_W'({wm_rdata_reg, {FRAC_W{1'b0}}});
                denom_next         = DEN_W'(total_reg);
                div_req_next.start = 1'b1;
                div_req_next.qbits = QBITS_PROB;
                state_next         = ST_DIV_PDF;
            end

            ST_DIV_PDF:
            begin
                if (div_done)
                begin
                    // probability never exceeds one
                    if (div_quot > QUO_W'(65536))
                    begin
                        res_prob_next = PROB_W'(65536);
                    end
                    else
                    begin
                        res_prob_next = div_quot[PROB_W-1:0];
                    end
                    state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                // hand the item to the output register once it is free
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = act_reg;
                    bin_next       = res_bin_reg;
                    pos_next       = res_pos_reg;
                    den_next       = res_den_reg;
                    prob_next      = res_prob_reg;
                    wtot_next      = res_total_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            bin_count_reg <= CNT_W'(MAX_BINS);
            total_reg     <= '0;
            act_reg       <= ACT_LOAD;
            idx_reg       <= '0;
            u_reg         <= '0;
            rd_idx_reg    <= '0;
            pend_reg      <= 1'b0;
            pend_addr_reg <= '0;
            acc_reg       <= '0;
            prod_reg      <= '0;
            start_reg     <= '0;
            len_reg       <= '0;
            k_reg         <= '0;
            pk_reg        <= '0;
            wk_reg        <= '0;
            d_reg         <= '0;
            kd_reg        <= '0;
            nd_reg        <= '0;
            frac_reg      <= '0;
            wn_reg        <= '0;
            div_req_reg   <= '0;
            numer_reg     <= '0;
            denom_reg     <= '0;
            res_bin_reg   <= '0;
            res_pos_reg   <= '0;
            res_den_reg   <= '0;
            res_prob_reg  <= '0;
            res_total_reg <= '0;
            out_valid_reg <= 1'b0;
            kind_reg      <= ACT_LOAD;
            bin_reg       <= '0;
            pos_reg       <= '0;
            den_reg       <= '0;
            prob_reg      <= '0;
            wtot_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            bin_count_reg <= bin_count_next;
            total_reg     <= total_next;
            act_reg       <= act_next;
            idx_reg       <= idx_next;
            u_reg         <= u_next;
            rd_idx_reg    <= rd_idx_next;
            pend_reg      <= pend_next;
            pend_addr_reg <= pend_addr_next;
            acc_reg       <= acc_next;
            prod_reg      <= prod_next;
            start_reg     <= start_next;
            len_reg       <= len_next;
            k_reg         <= k_next;
            pk_reg        <= pk_next;
            wk_reg        <= wk_next;
            d_reg         <= d_next;
            kd_reg        <= kd_next;
            nd_reg        <= nd_next;
            frac_reg      <= frac_next;
            wn_reg        <= wn_next;
            div_req_reg   <= div_req_next;
            numer_reg     <= numer_next;
            denom_reg     <= denom_next;
            res_bin_reg   <= res_bin_next;
            res_pos_reg   <= res_pos_next;
            res_den_reg   <= res_den_next;
            res_prob_reg  <= res_prob_next;
            res_total_reg <= res_total_next;
            out_valid_reg <= out_valid_next;
            kind_reg      <= kind_next;
            bin_reg       <= bin_next;
            pos_reg       <= pos_next;
            den_reg       <= den_next;
            prob_reg      <= prob_next;
            wtot_reg      <= wtot_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign kind         = kind_reg;
    assign chosen_bin   = bin_reg;
    assign position     = pos_reg;
    assign density      = den_reg;
    assign probability  = prob_reg;
    assign weight_total = wtot_reg;

endmodule
